[hdl/srt_pkg.sv]
// Shared types and codes for the sparse radix table.
// No dependencies; every other file of the block but srt_ram refers to this package.
`default_nettype none

package srt_pkg;

   localparam int TOTAL_W = 25;
   localparam int KEY_W   = 24;

   typedef enum logic [1:0] {
      ACT_LOOKUP = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_DELETE = 2'd2,
      ACT_SPARE  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STS_OK      = 2'd0,
      STS_MISSING = 2'd1,
      STS_PRESENT = 2'd2,
      STS_NO_NODE = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_WALK_RD, ST_WALK_CHK, ST_DECIDE, ST_POP_RD, ST_POP,
      ST_FILL_INC, ST_LEAF_WR, ST_LEAF_INC, ST_DEL_LEAF, ST_DEL_DEC, ST_DEL_CHK,
      ST_DONE
   } ctrl_state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_CLEAR, OP_LOAD, OP_WALK_RD, OP_WALK_CHK, OP_DECIDE, OP_POP_RD,
      OP_POP, OP_FILL_INC, OP_LEAF_WR, OP_LEAF_INC, OP_DEL_LEAF, OP_DEL_DEC,
      OP_DEL_CHK, OP_PUBLISH
   } dp_op_type;

   typedef struct packed {
      logic clear_done;
      logic root_valid;
      logic slot_valid;
      logic lvl_zero;
      logic lvl_one;
      logic lvl_top;
      logic r_zero;
      logic hit;
      logic no_node;
      logic is_insert;
      logic is_delete;
      logic fill_zero;
      logic out_busy;
   } dp_status_type;

endpackage

`default_nettype wire

[hdl/srt_chan_if.sv]
// Request and response channel interfaces of the sparse radix table.
// Depends on srt_pkg for the field types.
`default_nettype none

interface srt_req_if #(parameter int ENTRY_BITS = 32);
   logic                         valid;
   logic                         ready;
   srt_pkg::action_type          action;
   logic [srt_pkg::KEY_W-1:0]    key_index;
   logic [ENTRY_BITS-1:0]        entry_in;
   modport source (output valid, action, key_index, entry_in, input ready);
   modport sink (input valid, action, key_index, entry_in, output ready);
endinterface

interface srt_rsp_if #(parameter int ENTRY_BITS = 32);
   logic                         valid;
   logic                         ready;
   logic                         found;
   logic [ENTRY_BITS-1:0]        entry_out;
   srt_pkg::status_type          status;
   logic [srt_pkg::TOTAL_W-1:0]  total_entries;
   modport source (output valid, found, entry_out, status, total_entries, input ready);
   modport sink (input valid, found, entry_out, status, total_entries, output ready);
endinterface

`default_nettype wire

[hdl/srt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module srt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/srt_ctrl.sv]
// Controller state machine of the sparse radix table.
// Depends on srt_pkg; drives srt_dp through one operation code per cycle.
`default_nettype none

module srt_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire srt_pkg::dp_status_type sts,
   output srt_pkg::dp_op_type         op
);

   srt_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srt_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srt_pkg::ST_CLEAR:    if (sts.clear_done) state_in = srt_pkg::ST_IDLE;
         srt_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = sts.root_valid ? srt_pkg::ST_WALK_RD : srt_pkg::ST_DECIDE;
            end
         end
         srt_pkg::ST_WALK_RD:  state_in = srt_pkg::ST_WALK_CHK;
         srt_pkg::ST_WALK_CHK: begin
            state_in = (sts.slot_valid && !sts.lvl_zero) ? srt_pkg::ST_WALK_RD
                                                          : srt_pkg::ST_DECIDE;
         end
         srt_pkg::ST_DECIDE: begin
            priority if (sts.is_insert) begin
               priority if ((sts.r_zero && sts.hit) || sts.no_node) begin
                  state_in = srt_pkg::ST_DONE;
               end else if (sts.r_zero) begin
                  state_in = srt_pkg::ST_LEAF_WR;
               end else begin
                  state_in = srt_pkg::ST_POP_RD;
               end
            end else if (sts.is_delete && sts.hit) begin
               state_in = srt_pkg::ST_DEL_LEAF;
            end else begin
               state_in = srt_pkg::ST_DONE;
            end
         end
         srt_pkg::ST_POP_RD:   state_in = srt_pkg::ST_POP;
         srt_pkg::ST_POP:      state_in = sts.root_valid ? srt_pkg::ST_FILL_INC
                                                         : srt_pkg::ST_POP_RD;
         srt_pkg::ST_FILL_INC: state_in = sts.lvl_one ? srt_pkg::ST_LEAF_WR
                                                      : srt_pkg::ST_POP_RD;
         srt_pkg::ST_LEAF_WR:  state_in = srt_pkg::ST_LEAF_INC;
         srt_pkg::ST_LEAF_INC: state_in = srt_pkg::ST_DONE;
         srt_pkg::ST_DEL_LEAF: state_in = srt_pkg::ST_DEL_DEC;
         srt_pkg::ST_DEL_DEC:  state_in = srt_pkg::ST_DEL_CHK;
         srt_pkg::ST_DEL_CHK: begin
            state_in = (!sts.fill_zero || sts.lvl_top) ? srt_pkg::ST_DONE
                                                       : srt_pkg::ST_DEL_DEC;
         end
         srt_pkg::ST_DONE:     if (!sts.out_busy) state_in = srt_pkg::ST_IDLE;
         default:              state_in = srt_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      op        = srt_pkg::OP_NONE;
      unique case (state_ff)
         srt_pkg::ST_CLEAR:    op = srt_pkg::OP_CLEAR;
         srt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) op = srt_pkg::OP_LOAD;
         end
         srt_pkg::ST_WALK_RD:  op = srt_pkg::OP_WALK_RD;
         srt_pkg::ST_WALK_CHK: op = srt_pkg::OP_WALK_CHK;
         srt_pkg::ST_DECIDE:   op = srt_pkg::OP_DECIDE;
         srt_pkg::ST_POP_RD:   op = srt_pkg::OP_POP_RD;
         srt_pkg::ST_POP:      op = srt_pkg::OP_POP;
         srt_pkg::ST_FILL_INC: op = srt_pkg::OP_FILL_INC;
         srt_pkg::ST_LEAF_WR:  op = srt_pkg::OP_LEAF_WR;
         srt_pkg::ST_LEAF_INC: op = srt_pkg::OP_LEAF_INC;
         srt_pkg::ST_DEL_LEAF: op = srt_pkg::OP_DEL_LEAF;
         srt_pkg::ST_DEL_DEC:  op = srt_pkg::OP_DEL_DEC;
         srt_pkg::ST_DEL_CHK:  op = srt_pkg::OP_DEL_CHK;
         srt_pkg::ST_DONE:     if (!sts.out_busy) op = srt_pkg::OP_PUBLISH;
         default:              op = srt_pkg::OP_NONE;
      endcase
   end

endmodule

`default_nettype wire

[hdl/srt_dp.sv]
// Datapath of the sparse radix table: slot, fill and free-node memories,
// walk registers and the response register. Depends on srt_pkg and srt_ram.
`default_nettype none

module srt_dp #(
   parameter int LEVELS     = 4,
   parameter int SLOT_BITS  = 6,
   parameter int NODE_COUNT = 256,
   parameter int ENTRY_BITS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire srt_pkg::dp_op_type            op,
   output srt_pkg::dp_status_type             sts,
   input  wire srt_pkg::action_type           req_action,
   input  wire logic [srt_pkg::KEY_W-1:0]     req_key_index,
   input  wire logic [ENTRY_BITS-1:0]         req_entry_in,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic                               rsp_found,
   output logic [ENTRY_BITS-1:0]              rsp_entry_out,
   output srt_pkg::status_type                rsp_status,
   output logic [srt_pkg::TOTAL_W-1:0]        rsp_total_entries
);

   localparam int NB    = $clog2(NODE_COUNT);
   localparam int SA    = $clog2(NODE_COUNT << SLOT_BITS);
   localparam int DEPTH = NODE_COUNT << SLOT_BITS;
   localparam int VW    = (ENTRY_BITS > NB) ? ENTRY_BITS : NB;
   localparam int SW    = VW + 1;
   localparam int FW    = SLOT_BITS + 1;
   localparam int FTW   = $clog2(NODE_COUNT + 1);
   localparam int LW    = $clog2(LEVELS + 1);
   localparam int PW    = $clog2(LEVELS);
   localparam int KW    = LEVELS * SLOT_BITS;

   srt_pkg::action_type          act_ff;
   logic [srt_pkg::KEY_W-1:0]    key_ff;
   logic [ENTRY_BITS-1:0]        entry_ff;
   logic [NB-1:0]                node_ff;
   logic [NB-1:0]                path_ff [LEVELS];
   logic [LW-1:0]                lvl_ff;
   logic [LW-1:0]                r_ff;
   logic                         hit_ff;
   logic [VW-1:0]                leaf_ff;
   logic [NB-1:0]                root_ff;
   logic                         root_valid_ff;
   logic [srt_pkg::TOTAL_W-1:0]  total_ff;
   logic [FTW-1:0]               free_top_ff;
   logic [FW-1:0]                newv_ff;
   logic                         found_ff;
   logic [ENTRY_BITS-1:0]        eout_ff;
   srt_pkg::status_type          status_ff;
   logic [SA-1:0]                clr_cnt_ff;
   logic                         rsp_valid_ff;
   logic                         rsp_found_ff;
   logic [ENTRY_BITS-1:0]        rsp_entry_ff;
   srt_pkg::status_type          rsp_status_ff;
   logic [srt_pkg::TOTAL_W-1:0]  rsp_total_ff;

   logic [PW-1:0]                lvl_idx;
   logic [PW-1:0]                lvl_up_idx;
   logic [LW-1:0]                lvl_up;
   logic                         clr_low;
   logic [KW+srt_pkg::KEY_W-1:0] key_wide;
   logic [KW-1:0]                key_pad;

   logic                         slot_we;
   logic [SA-1:0]                slot_waddr;
   logic [SW-1:0]                slot_wdata;
   logic [SA-1:0]                slot_raddr;
   logic [SW-1:0]                slot_rdata;
   logic                         fill_we;
   logic [NB-1:0]                fill_waddr;
   logic [FW-1:0]                fill_wdata;
   logic [NB-1:0]                fill_raddr;
   logic [FW-1:0]                fill_rdata;
   logic                         stk_we;
   logic [NB-1:0]                stk_waddr;
   logic [NB-1:0]                stk_wdata;
   logic [NB-1:0]                stk_raddr;
   logic [NB-1:0]                stk_rdata;
   logic [FW-1:0]                fill_dec;

   function automatic logic [SLOT_BITS-1:0] digit_of(input logic [KW-1:0] k,
                                                     input logic [LW-1:0] l);
      logic [KW-1:0] sh;
      sh = k >> (int'(l) * SLOT_BITS);
      return sh[SLOT_BITS-1:0];
   endfunction

   assign key_wide   = {{KW{1'b0}}, key_ff};
   assign key_pad    = key_wide[KW-1:0];
   assign lvl_idx    = lvl_ff[PW-1:0];
   assign lvl_up     = lvl_ff + LW'(1);
   assign lvl_up_idx = lvl_up[PW-1:0];
   assign clr_low    = (int'(clr_cnt_ff) < NODE_COUNT);
   assign fill_dec   = (fill_rdata == '0) ? '0 : fill_rdata - FW'(1);

   always_comb begin
      slot_we    = 1'b0;
      slot_waddr = {path_ff[lvl_idx], digit_of(key_pad, lvl_ff)};
      slot_wdata = '0;
      slot_raddr = {node_ff, digit_of(key_pad, lvl_ff)};
      fill_we    = 1'b0;
      fill_waddr = path_ff[lvl_idx];
      fill_wdata = fill_rdata + FW'(1);
      fill_raddr = path_ff[lvl_idx];
      stk_we     = 1'b0;
      stk_waddr  = free_top_ff[NB-1:0];
      stk_wdata  = path_ff[lvl_idx];
      stk_raddr  = NB'(free_top_ff - FTW'(1));
      unique case (op)
         srt_pkg::OP_CLEAR: begin
            slot_we    = 1'b1;
            slot_waddr = clr_cnt_ff;
            fill_we    = clr_low;
            fill_waddr = clr_cnt_ff[NB-1:0];
            fill_wdata = '0;
            stk_we     = clr_low;
            stk_waddr  = clr_cnt_ff[NB-1:0];
            stk_wdata  = NB'(NODE_COUNT - 1 - int'(clr_cnt_ff));
         end
         srt_pkg::OP_POP: begin
            slot_we    = root_valid_ff;
            slot_wdata = {1'b1, VW'(stk_rdata)};
         end
         srt_pkg::OP_FILL_INC, srt_pkg::OP_LEAF_INC: begin
            fill_we = 1'b1;
         end
         srt_pkg::OP_LEAF_WR: begin
            slot_we    = 1'b1;
            slot_waddr = {path_ff[0], digit_of(key_pad, '0)};
            slot_wdata = {1'b1, VW'(entry_ff)};
            fill_raddr = path_ff[0];
         end
         srt_pkg::OP_DEL_LEAF: begin
            slot_we    = 1'b1;
            slot_waddr = {path_ff[0], digit_of(key_pad, '0)};
            fill_raddr = path_ff[0];
         end
         srt_pkg::OP_DEL_DEC: begin
            fill_we    = 1'b1;
            fill_wdata = fill_dec;
         end
         srt_pkg::OP_DEL_CHK: begin
            stk_we = (newv_ff == '0) && (int'(free_top_ff) < NODE_COUNT);
            if (newv_ff == '0 && int'(lvl_ff) != LEVELS - 1) begin
               slot_we    = 1'b1;
               slot_waddr = {path_ff[lvl_up_idx], digit_of(key_pad, lvl_up)};
               fill_raddr = path_ff[lvl_up_idx];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff       <= '0;
         root_valid_ff <= 1'b0;
         total_ff      <= '0;
         free_top_ff   <= FTW'(NODE_COUNT);
         clr_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && op != srt_pkg::OP_PUBLISH) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (op)
            srt_pkg::OP_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + SA'(1);
            end
            srt_pkg::OP_LOAD: begin
               act_ff    <= req_action;
               key_ff    <= req_key_index;
               entry_ff  <= req_entry_in;
               node_ff   <= root_ff;
               lvl_ff    <= LW'(LEVELS - 1);
               r_ff      <= LW'(LEVELS);
               hit_ff    <= 1'b0;
               found_ff  <= 1'b0;
               eout_ff   <= '0;
               status_ff <= srt_pkg::STS_OK;
            end
            srt_pkg::OP_WALK_RD: begin
               path_ff[lvl_idx] <= node_ff;
            end
            srt_pkg::OP_WALK_CHK: begin
               if (slot_rdata[SW-1] && lvl_ff != '0) begin
                  node_ff <= slot_rdata[NB-1:0];
                  lvl_ff  <= lvl_ff - LW'(1);
               end else begin
                  r_ff    <= lvl_ff;
                  hit_ff  <= slot_rdata[SW-1];
                  leaf_ff <= slot_rdata[VW-1:0];
               end
            end
            srt_pkg::OP_DECIDE: begin
               if (act_ff == srt_pkg::ACT_INSERT) begin
                  if (r_ff == '0 && hit_ff) begin
                     status_ff <= srt_pkg::STS_PRESENT;
                  end else if (sts.no_node) begin
                     status_ff <= srt_pkg::STS_NO_NODE;
                  end else begin
                     lvl_ff <= (int'(r_ff) == LEVELS) ? LW'(LEVELS - 1) : r_ff;
                  end
               end else if (hit_ff) begin
                  found_ff <= 1'b1;
                  eout_ff  <= leaf_ff[ENTRY_BITS-1:0];
               end else begin
                  status_ff <= srt_pkg::STS_MISSING;
               end
            end
            srt_pkg::OP_POP: begin
               free_top_ff <= free_top_ff - FTW'(1);
               if (!root_valid_ff) begin
                  root_ff                <= stk_rdata;
                  root_valid_ff          <= 1'b1;
                  path_ff[LEVELS - 1]    <= stk_rdata;
               end else begin
                  path_ff[PW'(lvl_ff - LW'(1))] <= stk_rdata;
               end
            end
            srt_pkg::OP_FILL_INC: begin
               lvl_ff <= lvl_ff - LW'(1);
            end
            srt_pkg::OP_LEAF_INC: begin
               total_ff <= total_ff + srt_pkg::TOTAL_W'(1);
            end
            srt_pkg::OP_DEL_LEAF: begin
               total_ff <= total_ff - srt_pkg::TOTAL_W'(1);
               lvl_ff   <= '0;
            end
            srt_pkg::OP_DEL_DEC: begin
               newv_ff <= fill_dec;
            end
            srt_pkg::OP_DEL_CHK: begin
               if (newv_ff == '0) begin
                  if (int'(free_top_ff) < NODE_COUNT) begin
                     free_top_ff <= free_top_ff + FTW'(1);
                  end
                  if (int'(lvl_ff) == LEVELS - 1) begin
                     root_ff       <= '0;
                     root_valid_ff <= 1'b0;
                  end else begin
                     lvl_ff <= lvl_up;
                  end
               end
            end
            srt_pkg::OP_PUBLISH: begin
               rsp_valid_ff  <= 1'b1;
               rsp_found_ff  <= found_ff;
               rsp_entry_ff  <= eout_ff;
               rsp_status_ff <= status_ff;
               rsp_total_ff  <= total_ff;
            end
            default: begin
            end
         endcase
      end
   end

   srt_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (slot_raddr),
      .rd_data (slot_rdata)
   );

   srt_ram #(.WIDTH(FW), .DEPTH(NODE_COUNT)) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_we),
      .wr_addr (fill_waddr),
      .wr_data (fill_wdata),
      .rd_addr (fill_raddr),
      .rd_data (fill_rdata)
   );

   srt_ram #(.WIDTH(NB), .DEPTH(NODE_COUNT)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   always_comb begin
      sts.clear_done = (int'(clr_cnt_ff) == DEPTH - 1);
      sts.root_valid = root_valid_ff;
      sts.slot_valid = slot_rdata[SW-1];
      sts.lvl_zero   = (lvl_ff == '0);
      sts.lvl_one    = (lvl_ff == LW'(1));
      sts.lvl_top    = (int'(lvl_ff) == LEVELS - 1);
      sts.r_zero     = (r_ff == '0);
      sts.hit        = hit_ff;
      sts.no_node    = (int'(free_top_ff) < int'(r_ff));
      sts.is_insert  = (act_ff == srt_pkg::ACT_INSERT);
      sts.is_delete  = (act_ff == srt_pkg::ACT_DELETE);
      sts.fill_zero  = (newv_ff == '0);
      sts.out_busy   = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_entry_out     = rsp_entry_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_total_entries = rsp_total_ff;

endmodule

`default_nettype wire

[hdl/sparse_radix_table.sv]
// Sparse radix table: the time from an accepted request to its response is set by the
// walk through the slot RAM, node pops and fill updates on insert and pruning on delete,
// plus any stall of the response. One request is worked at a time: the next is taken
// only once the response of the last is published. After reset a clearing pass over all
// NODE_COUNT * 2^SLOT_BITS slots (16384 by default) empties the slot RAM, zeroes the fill
// counts and stacks the free nodes; no request is taken until it ends. Uses srt_ctrl and srt_dp.
`default_nettype none

module sparse_radix_table #(
   parameter int LEVELS     = 4,
   parameter int SLOT_BITS  = 6,
   parameter int NODE_COUNT = 256,
   parameter int ENTRY_BITS = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   srt_req_if.sink   req_chan,
   srt_rsp_if.source rsp_chan
);

   srt_pkg::dp_op_type     op;
   srt_pkg::dp_status_type sts;

   srt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .op        (op)
   );

   srt_dp #(
      .LEVELS     (LEVELS),
      .SLOT_BITS  (SLOT_BITS),
      .NODE_COUNT (NODE_COUNT),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .op                (op),
      .sts               (sts),
      .req_action        (req_chan.action),
      .req_key_index     (req_chan.key_index),
      .req_entry_in      (req_chan.entry_in),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_found         (rsp_chan.found),
      .rsp_entry_out     (rsp_chan.entry_out),
      .rsp_status        (rsp_chan.status),
      .rsp_total_entries (rsp_chan.total_entries)
   );

endmodule

`default_nettype wire

[bench/srt_checker.sv]
// Checker for the sparse radix table: watches the request and response channels,
// predicts each response from its own map model and compares field by field.
// Depends on srt_pkg and the channel interfaces in srt_chan_if.
`timescale 1ns / 100ps
`default_nettype none

module srt_checker (
   input  wire logic clock,
   input  wire logic reset,
   srt_req_if        req_mon,
   srt_rsp_if        rsp_mon,
   output int        fail_count,
   output int        pending_count
);

   localparam int LVLS  = 4;
   localparam int SBITS = 6;
   localparam int NODES = 256;

   typedef struct {
      logic                 found;
      logic [31:0]          entry;
      srt_pkg::status_type  status;
      logic [24:0]          total;
   } rsp_item_type;

   logic [31:0] slot_val [NODES*64];
   bit          slot_used[NODES*64];
   int          fill     [NODES];
   int          root_id;
   bit          root_ok;
   logic [24:0] entry_total;
   int          free_ids [NODES];
   int          free_top;
   rsp_item_type expected_rsps[$];

   function automatic int slot_of(int node, logic [23:0] key, int lvl);
      return (node << SBITS) | int'((key >> (lvl * SBITS)) & 6'h3f);
   endfunction

   function automatic int take_node();
      if (free_top == 0) return 0;
      free_top--;
      return free_ids[free_top];
   endfunction

   function automatic void give_node(int n);
      if (free_top < NODES) begin
         free_ids[free_top] = n;
         free_top++;
      end
   endfunction

   function automatic void clear_map();
      foreach (slot_used[i]) begin
         slot_used[i] = 0;
         slot_val[i]  = '0;
      end
      foreach (fill[i]) fill[i] = 0;
      for (int i = 0; i < NODES; i++) free_ids[i] = NODES - 1 - i;
      free_top    = NODES;
      root_id     = 0;
      root_ok     = 0;
      entry_total = '0;
   endfunction

   function automatic rsp_item_type apply_request(srt_pkg::action_type act,
                                                  logic [23:0] key,
                                                  logic [31:0] entry);
      rsp_item_type res;
      int path[LVLS];
      int miss;
      int node;
      int idx;
      int start;
      int n;
      int parent;
      res = '{1'b0, 32'd0, srt_pkg::STS_OK, 25'd0};
      foreach (path[i]) path[i] = 0;
      miss = LVLS;
      if (root_ok) begin
         node = root_id;
         miss = 0;
         for (int l = LVLS - 1; l >= 1; l--) begin
            idx = slot_of(node, key, l);
            path[l] = node;
            if (!slot_used[idx]) begin
               miss = l;
               break;
            end
            node = int'(slot_val[idx]) % NODES;
         end
         if (miss == 0) path[0] = node;
      end
      if (act == srt_pkg::ACT_INSERT) begin
         if (miss == 0 && slot_used[slot_of(path[0], key, 0)]) begin
            res.status = srt_pkg::STS_PRESENT;
         end else if (free_top < miss) begin
            res.status = srt_pkg::STS_NO_NODE;
         end else begin
            start = miss;
            if (miss == LVLS) begin
               root_id = take_node();
               root_ok = 1;
               path[LVLS-1] = root_id;
               start = LVLS - 1;
            end
            for (int l = start; l >= 1; l--) begin
               idx = slot_of(path[l], key, l);
               n = take_node();
               slot_val[idx]  = n;
               slot_used[idx] = 1;
               fill[path[l]]++;
               path[l-1] = n;
            end
            idx = slot_of(path[0], key, 0);
            slot_val[idx]  = entry;
            slot_used[idx] = 1;
            fill[path[0]]++;
            entry_total++;
         end
      end else begin
         idx = slot_of(path[0], key, 0);
         if (miss != 0 || !slot_used[idx]) begin
            res.status = srt_pkg::STS_MISSING;
         end else begin
            res.found = 1;
            res.entry = slot_val[idx];
            if (act == srt_pkg::ACT_DELETE) begin
               slot_val[idx]  = '0;
               slot_used[idx] = 0;
               if (fill[path[0]] > 0) fill[path[0]]--;
               entry_total--;
               for (int l = 0; l < LVLS - 1; l++) begin
                  parent = path[l+1];
                  if (fill[path[l]] != 0) break;
                  give_node(path[l]);
                  idx = slot_of(parent, key, l + 1);
                  slot_val[idx]  = '0;
                  slot_used[idx] = 0;
                  if (fill[parent] > 0) fill[parent]--;
               end
               if (fill[root_id] == 0) begin
                  give_node(root_id);
                  root_id = 0;
                  root_ok = 0;
               end
            end
         end
      end
      res.total = entry_total;
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count    = 0;
      pending_count = 0;
      clear_map();
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready)
            expected_rsps.push_back(apply_request(req_mon.action, req_mon.key_index,
                                                  req_mon.entry_in));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected transaction", 32'd0, 32'd0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_mon.found !== want.found)
                  report_mismatch("found", 32'(rsp_mon.found), 32'(want.found));
               if (rsp_mon.entry_out !== want.entry)
                  report_mismatch("entry_out", rsp_mon.entry_out, want.entry);
               if (rsp_mon.status !== want.status)
                  report_mismatch("status", 32'(rsp_mon.status), 32'(want.status));
               if (rsp_mon.total_entries !== want.total)
                  report_mismatch("total_entries", 32'(rsp_mon.total_entries),
                                  32'(want.total));
            end
         end
         pending_count = expected_rsps.size();
      end
   end

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Top of the sparse radix table testbench: clock, reset, request stimulus with
// random idling, response stalls, watchdog and verdict. Depends on srt_pkg,
// srt_chan_if, sparse_radix_table and srt_checker.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

   localparam int WATCHDOG_LIMIT = 100000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   int   req_idle_pct;
   int   rsp_idle_pct;
   int   quiet_cycles;
   logic [23:0] key_pool[$];

   srt_req_if #(.ENTRY_BITS(32)) req_chan();
   srt_rsp_if #(.ENTRY_BITS(32)) rsp_chan();

   sparse_radix_table i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   srt_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #4 clock = ~clock;

   always @(negedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_request(srt_pkg::action_type act, logic [23:0] key,
                               logic [31:0] entry);
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.action    <= act;
      req_chan.key_index <= key;
      req_chan.entry_in  <= entry;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [23:0] pick_key();
      logic [23:0] k;
      case ($urandom_range(3))
         0: k = 24'($urandom);
         1: k = {6'($urandom_range(1)), 6'($urandom_range(3)), 6'($urandom_range(3)),
                 6'($urandom)};
         default: k = (key_pool.size() > 0) ? key_pool[$urandom_range(key_pool.size() - 1)]
                                            : 24'($urandom);
      endcase
      return k;
   endfunction

   task automatic run_random(int count);
      srt_pkg::action_type act;
      logic [23:0]         key;
      for (int i = 0; i < count; i++) begin
         key = pick_key();
         case ($urandom_range(9))
            0, 1, 2, 3: act = srt_pkg::ACT_INSERT;
            4, 5, 6:    act = srt_pkg::ACT_DELETE;
            7, 8:       act = srt_pkg::ACT_LOOKUP;
            default:    act = srt_pkg::ACT_SPARE;
         endcase
         if (act == srt_pkg::ACT_INSERT && key_pool.size() < 200) key_pool.push_back(key);
         send_request(act, key, $urandom);
      end
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin
      req_chan.valid     = 1'b0;
      req_chan.action    = srt_pkg::ACT_LOOKUP;
      req_chan.key_index = '0;
      req_chan.entry_in  = '0;
      rsp_chan.ready     = 1'b0;
      req_idle_pct = 25;
      rsp_idle_pct = 65;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_request(srt_pkg::ACT_LOOKUP, 24'h000000, 32'h0);
      send_request(srt_pkg::ACT_DELETE, 24'hFFFFFF, 32'h0);
      send_request(srt_pkg::ACT_INSERT, 24'h000000, 32'h0);
      send_request(srt_pkg::ACT_LOOKUP, 24'h000000, 32'hFFFFFFFF);
      send_request(srt_pkg::ACT_INSERT, 24'h000000, 32'h1234);
      send_request(srt_pkg::ACT_INSERT, 24'hFFFFFF, 32'hFFFFFFFF);
      send_request(srt_pkg::ACT_SPARE,  24'hFFFFFF, 32'h5);
      send_request(srt_pkg::ACT_INSERT, 24'hAAAAAA, 32'hAAAAAAAA);
      send_request(srt_pkg::ACT_INSERT, 24'h555555, 32'h55555555);
      send_request(srt_pkg::ACT_LOOKUP, 24'h555554, 32'h0);
      send_request(srt_pkg::ACT_DELETE, 24'hFFFFFF, 32'h0);
      send_request(srt_pkg::ACT_DELETE, 24'hFFFFFF, 32'h0);
      send_request(srt_pkg::ACT_DELETE, 24'h000000, 32'h0);
      send_request(srt_pkg::ACT_DELETE, 24'hAAAAAA, 32'h0);
      send_request(srt_pkg::ACT_DELETE, 24'h555555, 32'h0);
      send_request(srt_pkg::ACT_LOOKUP, 24'h555555, 32'h0);
      // Spread keys over distinct pairs of top two digits until the node pool runs dry.
      for (int i = 0; i < 100; i++)
         send_request(srt_pkg::ACT_INSERT, {6'(i), 6'(i >> 6), 6'(i), 6'(i)}, 32'(i));
      wait_drained();
      for (int i = 0; i < 100; i++)
         send_request(srt_pkg::ACT_DELETE, {6'(i), 6'(i >> 6), 6'(i), 6'(i)}, 32'h0);

      run_random(400);
      req_idle_pct = 65;
      rsp_idle_pct = 25;
      run_random(400);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random(280);

      wait_drained();
      repeat (64) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
